// ----- hw/rtl/ipv4_fragment_reassembly_tracker_assert.svh -----
// Assertion macros shared by the reassembly tracker modules.
`ifndef IPV4_FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH
`define IPV4_FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define IPVFR_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define IPVFR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define IPVFR_ASSERT(lbl, cond, msg)
`define IPVFR_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/ipvfr_pkg.sv -----
// Types and constants of the IPv4 fragment reassembly tracker.
`timescale 1ns / 1ps
package ipvfr_pkg;
	localparam int MAX_CONTEXTS = 4;
	localparam int MAX_FRAGMENTS = 16;
	localparam int CTX_W = (MAX_CONTEXTS > 1) ? $clog2(MAX_CONTEXTS) : 1;
	localparam int FRAG_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
	localparam int CNT_W = $clog2(MAX_FRAGMENTS + 1);
	localparam int ADDR_W = CTX_W + FRAG_W;
	localparam int MEM_DEPTH = 2 ** ADDR_W;
	localparam int SUM_W = 21;

	localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;
	localparam logic [3:0] IPVERSION = 4'd4;

	// Configuration register indexes.
	localparam logic [7:0] REG_MY_ADDRESS = 8'd0;
	localparam logic [7:0] REG_EXPECTED_PROTOCOL = 8'd1;

	// Result status codes.
	localparam logic [3:0] ST_WHOLE = 4'd0;
	localparam logic [3:0] ST_REASSEMBLED = 4'd1;
	localparam logic [3:0] ST_HELD = 4'd2;
	localparam logic [3:0] ST_DUPLICATE = 4'd3;
	localparam logic [3:0] ST_VERSION_PROTO = 4'd4;
	localparam logic [3:0] ST_SHORT = 4'd5;
	localparam logic [3:0] ST_BAD_HEADER = 4'd6;
	localparam logic [3:0] ST_BAD_LENGTH = 4'd7;
	localparam logic [3:0] ST_NOT_OURS = 4'd8;
	localparam logic [3:0] ST_NO_ROOM = 4'd9;

	// Classified header handed from the front end to the sequencer.
	typedef struct packed {
		logic [3:0] status;
		logic is_frag;
		logic [7:0] tag;
		logic [15:0] len;
		logic [31:0] src;
		logic [31:0] dst;
		logic [23:0] key;
		logic [12:0] off;
		logic mf;
	} item_t;

	// One stored fragment.
	typedef struct packed {
		logic [12:0] start;
		logic [15:0] bytes;
		logic more;
		logic [7:0] handle;
	} frag_t;
endpackage

// ----- hw/rtl/ipv4_fragment_reassembly_tracker.sv -----
// Top level of the IPv4 fragment reassembly tracker.
//
// Channel   Direction  Content
// s_axis    in         one received header descriptor per transaction
// m_axis    out        result or copy command, tlast on the final one of an input
// cfg       in         register writes (0 my_address, 1 expected_protocol)
//
// A rejected header or a whole packet goes from idle straight to the result
// state in the sequencer. A fragment passes through context match, a search of
// the stored fragments, a shift of the later ones, the insert and a contiguity
// walk, and on completion sends one copy command per stored fragment. The front
// end takes headers into a two-entry queue while the sequencer works. Reset
// clears all contexts at once. A stalled output holds the sequencer; the queue
// keeps taking headers until it is full.
`timescale 1ns / 1ps
module ipv4_fragment_reassembly_tracker (
	input  logic clk,
	input  logic arst_n,
	// ip_version, protocol, header_words, header_sum_ok, total_length,
	// received_length, src_addr, dst_addr, ident, frag_offset, more_fragments,
	// buffer_tag, zero fill
	input  logic [151:0] s_axis_tdata,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// status, out_tag, dest_offset, chunk_length, assembled_length, zero fill
	output logic [63:0] m_axis_tdata,
	output logic m_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [7:0] cfg_index,
	input  logic [31:0] cfg_data
);
	ipvfr_pkg::item_t front_item, q_item;
	logic q_valid, q_ready;

	ipvfr_front u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.hdr(s_axis_tdata[150:0]), .item(front_item)
	);

	ipvfr_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(s_axis_tvalid), .push_ready(s_axis_tready), .push_item(front_item),
		.pop_valid(q_valid), .pop_ready(q_ready), .pop_item(q_item)
	);

	ipvfr_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_data(m_axis_tdata), .out_last(m_axis_tlast)
	);
endmodule

// ----- hw/rtl/ipvfr_front.sv -----
// Front end: configuration registers and header classification.
`timescale 1ns / 1ps
module ipvfr_front (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [7:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [150:0] hdr,
	output ipvfr_pkg::item_t item
);
	logic [31:0] my_address_q;
	logic [7:0] exp_proto_q;
	logic [3:0] ver, hwords;
	logic [7:0] proto, tag;
	logic sum_ok, mf;
	logic [15:0] total, recv, ident, hlen, len_a, len_b;
	logic [31:0] src, dst;
	logic [12:0] off;

	assign cfg_ready = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_address_q <= '0;
			exp_proto_q <= 8'd17;
		end else if (cfg_valid) begin
			if (cfg_index == ipvfr_pkg::REG_MY_ADDRESS) my_address_q <= cfg_data;
			if (cfg_index == ipvfr_pkg::REG_EXPECTED_PROTOCOL) exp_proto_q <= cfg_data[7:0];
		end
	end

	// Unpack the header fields.
	assign ver = hdr[3:0];
	assign proto = hdr[11:4];
	assign hwords = hdr[15:12];
	assign sum_ok = hdr[16];
	assign total = hdr[32:17];
	assign recv = hdr[48:33];
	assign src = hdr[80:49];
	assign dst = hdr[112:81];
	assign ident = hdr[128:113];
	assign off = hdr[141:129];
	assign mf = hdr[142];
	assign tag = hdr[150:143];
	assign hlen = {10'd0, hwords, 2'b00};
	assign len_a = recv - hlen + ipvfr_pkg::MIN_HEADER_BYTES;
	assign len_b = total - hlen;

	// Checks in priority order; a whole packet gets the smaller payload length.
	always_comb begin
		item = '0;
		item.tag = tag;
		item.src = src;
		item.dst = dst;
		item.key = {ident, proto};
		item.off = off;
		item.mf = mf;
		if (ver != ipvfr_pkg::IPVERSION || proto != exp_proto_q) begin
			item.status = ipvfr_pkg::ST_VERSION_PROTO;
		end else if (recv < ipvfr_pkg::MIN_HEADER_BYTES) begin
			item.status = ipvfr_pkg::ST_SHORT;
		end else if (hlen < ipvfr_pkg::MIN_HEADER_BYTES || !sum_ok) begin
			item.status = ipvfr_pkg::ST_BAD_HEADER;
		end else if (recv < total || total < hlen) begin
			item.status = ipvfr_pkg::ST_BAD_LENGTH;
		end else if (my_address_q != '0 && dst != my_address_q) begin
			item.status = ipvfr_pkg::ST_NOT_OURS;
		end else if (!mf && off == '0) begin
			item.status = ipvfr_pkg::ST_WHOLE;
			item.len = (len_a < len_b) ? len_a : len_b;
		end else begin
			item.status = ipvfr_pkg::ST_HELD;
			item.is_frag = 1'b1;
			item.len = len_b;
		end
	end
endmodule

// ----- hw/rtl/ipvfr_queue.sv -----
// Two-entry queue between the classifier and the sequencer.
`timescale 1ns / 1ps
`include "ipv4_fragment_reassembly_tracker_assert.svh"
module ipvfr_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  ipvfr_pkg::item_t push_item,
	output logic pop_valid,
	input  logic pop_ready,
	output ipvfr_pkg::item_t pop_item
);
	ipvfr_pkg::item_t entry_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic push, pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_item = entry_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	// Storage.
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_item;
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`IPVFR_ASSERT(a_queue_level, count_q != 2'd3, "queue level beyond depth")
endmodule

// ----- hw/rtl/ipvfr_back.sv -----
// Sequencer: context lookup, sorted insert, contiguity walk and copy commands.
`timescale 1ns / 1ps
`include "ipv4_fragment_reassembly_tracker_assert.svh"
module ipvfr_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_ready,
	input  ipvfr_pkg::item_t q_item,
	output logic out_valid,
	input  logic out_ready,
	output logic [63:0] out_data,
	output logic out_last
);
	typedef enum logic [10:0] {
		S_IDLE      = 11'b00000000001,
		S_MATCH     = 11'b00000000010,
		S_SCAN      = 11'b00000000100,
		S_PLACE     = 11'b00000001000,
		S_SHIFT_RD  = 11'b00000010000,
		S_SHIFT_WR  = 11'b00000100000,
		S_INSERT    = 11'b00001000000,
		S_WALK0     = 11'b00010000000,
		S_WALK      = 11'b00100000000,
		S_EMIT_FRAG = 11'b01000000000,
		S_EMIT_ONE  = 11'b10000000000
	} state_t;

	localparam int CW = ipvfr_pkg::CTX_W;
	localparam int FW = ipvfr_pkg::FRAG_W;
	localparam int NW = ipvfr_pkg::CNT_W;

	state_t state_q;
	ipvfr_pkg::item_t item_q;
	logic [3:0] st_q;
	logic [CW-1:0] c_q;
	logic [NW-1:0] fcnt_q, pos_q, sh_q;
	logic [FW-1:0] i_q;
	logic [ipvfr_pkg::SUM_W-1:0] n_q, n_next;
	logic [16:0] run_q;

	logic ctx_valid_q [ipvfr_pkg::MAX_CONTEXTS];
	logic [31:0] ctx_src_q [ipvfr_pkg::MAX_CONTEXTS];
	logic [31:0] ctx_dst_q [ipvfr_pkg::MAX_CONTEXTS];
	logic [23:0] ctx_key_q [ipvfr_pkg::MAX_CONTEXTS];
	logic [NW-1:0] ctx_cnt_q [ipvfr_pkg::MAX_CONTEXTS];

	ipvfr_pkg::frag_t mem [ipvfr_pkg::MEM_DEPTH];
	ipvfr_pkg::frag_t rdata_q, wdata;
	logic [ipvfr_pkg::ADDR_W-1:0] raddr, waddr;
	logic we;

	logic hit, free;
	logic [CW-1:0] hit_idx, free_idx, c_sel;
	logic is_last, out_free;
	logic out_valid_q, out_last_q;
	logic [63:0] out_data_q;

	// Context lookup over the few context registers; the lowest index wins.
	always_comb begin
		hit = 1'b0;
		free = 1'b0;
		hit_idx = '0;
		free_idx = '0;
		for (int k = ipvfr_pkg::MAX_CONTEXTS - 1; k >= 0; k--) begin
			if (ctx_valid_q[k] && ctx_src_q[k] == item_q.src && ctx_dst_q[k] == item_q.dst
					&& ctx_key_q[k] == item_q.key) begin
				hit = 1'b1;
				hit_idx = CW'(k);
			end
			if (!ctx_valid_q[k]) begin
				free = 1'b1;
				free_idx = CW'(k);
			end
		end
		c_sel = hit ? hit_idx : free_idx;
	end

	assign q_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign is_last = ({1'b0, i_q} + NW'(1)) == fcnt_q;
	assign n_next = n_q + ipvfr_pkg::SUM_W'(rdata_q.bytes);

	// Fragment memory address and write port.
	always_comb begin
		raddr = {c_q, i_q};
		we = 1'b0;
		waddr = {c_q, sh_q[FW-1:0]};
		wdata = rdata_q;
		unique case (state_q)
			S_MATCH: raddr = {c_sel, FW'(0)};
			S_SCAN: raddr = {c_q, i_q + FW'(1)};
			// The walk wraps back to the first entry for the copy commands.
			S_WALK: raddr = is_last ? {c_q, FW'(0)} : {c_q, i_q + FW'(1)};
			S_SHIFT_RD: raddr = {c_q, FW'(sh_q - NW'(1))};
			S_SHIFT_WR: we = 1'b1;
			S_INSERT: begin
				we = 1'b1;
				waddr = {c_q, pos_q[FW-1:0]};
				wdata.start = item_q.off;
				wdata.bytes = item_q.len;
				wdata.more = item_q.mf;
				wdata.handle = item_q.tag;
			end
			S_WALK0: raddr = {c_q, FW'(0)};
			S_EMIT_FRAG: raddr = out_free ? {c_q, i_q + FW'(1)} : {c_q, i_q};
			default: raddr = {c_q, i_q};
		endcase
	end

	// Fragment memory.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// Item register.
	always_ff @(posedge clk) begin
		if (q_valid && state_q == S_IDLE) item_q <= q_item;
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q <= ipvfr_pkg::ST_WHOLE;
			c_q <= '0;
			fcnt_q <= '0;
			pos_q <= '0;
			sh_q <= '0;
			i_q <= '0;
			n_q <= '0;
			run_q <= '0;
			for (int k = 0; k < ipvfr_pkg::MAX_CONTEXTS; k++) begin
				ctx_valid_q[k] <= 1'b0;
				ctx_cnt_q[k] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						st_q <= q_item.status;
						state_q <= q_item.is_frag ? S_MATCH : S_EMIT_ONE;
					end
				end
				S_MATCH: begin
					i_q <= '0;
					pos_q <= '0;
					c_q <= c_sel;
					if (!hit && !free) begin
						st_q <= ipvfr_pkg::ST_NO_ROOM;
						state_q <= S_EMIT_ONE;
					end else if (hit) begin
						fcnt_q <= ctx_cnt_q[hit_idx];
						state_q <= (ctx_cnt_q[hit_idx] == '0) ? S_PLACE : S_SCAN;
					end else begin
						ctx_valid_q[free_idx] <= 1'b1;
						ctx_src_q[free_idx] <= item_q.src;
						ctx_dst_q[free_idx] <= item_q.dst;
						ctx_key_q[free_idx] <= item_q.key;
						ctx_cnt_q[free_idx] <= '0;
						fcnt_q <= '0;
						state_q <= S_PLACE;
					end
				end
				S_SCAN: begin
					if (rdata_q.start == item_q.off) begin
						st_q <= ipvfr_pkg::ST_DUPLICATE;
						state_q <= S_EMIT_ONE;
					end else if (item_q.off < rdata_q.start) begin
						pos_q <= {1'b0, i_q};
						state_q <= S_PLACE;
					end else if (is_last) begin
						pos_q <= fcnt_q;
						state_q <= S_PLACE;
					end else begin
						i_q <= i_q + FW'(1);
					end
				end
				S_PLACE: begin
					sh_q <= fcnt_q;
					if (fcnt_q >= NW'(ipvfr_pkg::MAX_FRAGMENTS)) begin
						ctx_valid_q[c_q] <= 1'b0;
						ctx_cnt_q[c_q] <= '0;
						st_q <= ipvfr_pkg::ST_NO_ROOM;
						state_q <= S_EMIT_ONE;
					end else begin
						state_q <= (fcnt_q > pos_q) ? S_SHIFT_RD : S_INSERT;
					end
				end
				S_SHIFT_RD: state_q <= S_SHIFT_WR;
				S_SHIFT_WR: begin
					sh_q <= sh_q - NW'(1);
					state_q <= ((sh_q - NW'(1)) == pos_q) ? S_INSERT : S_SHIFT_RD;
				end
				S_INSERT: begin
					fcnt_q <= fcnt_q + NW'(1);
					ctx_cnt_q[c_q] <= fcnt_q + NW'(1);
					state_q <= S_WALK0;
				end
				S_WALK0: begin
					i_q <= '0;
					n_q <= '0;
					state_q <= S_WALK;
				end
				S_WALK: begin
					if ({5'd0, rdata_q.start, 3'b000} != n_q) begin
						st_q <= ipvfr_pkg::ST_HELD;
						state_q <= S_EMIT_ONE;
					end else if (is_last) begin
						if (rdata_q.more) begin
							st_q <= ipvfr_pkg::ST_HELD;
							state_q <= S_EMIT_ONE;
						end else begin
							n_q <= n_next;
							run_q <= '0;
							i_q <= '0;
							state_q <= S_EMIT_FRAG;
						end
					end else begin
						n_q <= n_next;
						i_q <= i_q + FW'(1);
					end
				end
				S_EMIT_FRAG: begin
					if (out_free) begin
						run_q <= run_q + {1'b0, rdata_q.bytes};
						i_q <= i_q + FW'(1);
						if (is_last) begin
							for (int k = 0; k < ipvfr_pkg::MAX_CONTEXTS; k++) begin
								ctx_valid_q[k] <= 1'b0;
								ctx_cnt_q[k] <= '0;
							end
							state_q <= S_IDLE;
						end
					end
				end
				S_EMIT_ONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (state_q == S_EMIT_FRAG) || (state_q == S_EMIT_ONE);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && state_q == S_EMIT_FRAG) begin
			out_data_q <= {2'b00, n_q[16:0], rdata_q.bytes, run_q, rdata_q.handle,
				ipvfr_pkg::ST_REASSEMBLED};
			out_last_q <= is_last;
		end else if (out_free && state_q == S_EMIT_ONE) begin
			if (st_q == ipvfr_pkg::ST_WHOLE) begin
				out_data_q <= {2'b00, 1'b0, item_q.len, item_q.len, 17'd0, item_q.tag, st_q};
			end else begin
				out_data_q <= {2'b00, 17'd0, 16'd0, 17'd0, item_q.tag, st_q};
			end
			out_last_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;
	assign out_last = out_last_q;

	`IPVFR_ASSERT(a_state_onehot, $onehot(state_q), "sequencer state not one-hot")
	`IPVFR_ASSERT_IMP(a_walk_ctx_valid, state_q == S_WALK || state_q == S_EMIT_FRAG,
		ctx_valid_q[c_q], "walk on a context that is not valid")
	`IPVFR_ASSERT_IMP(a_insert_room, state_q == S_INSERT,
		fcnt_q < NW'(ipvfr_pkg::MAX_FRAGMENTS), "insert into a full context")
endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the IPv4 fragment reassembly tracker.
`timescale 1ns / 1ps
module tb_top;
	import ipvfr_pkg::*;

	// One header descriptor as driven on the input stream.
	typedef struct {
		logic [3:0] ver;
		logic [7:0] proto;
		logic [3:0] hwords;
		logic sum_ok;
		logic [15:0] total;
		logic [15:0] recv;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] ident;
		logic [12:0] off;
		logic mf;
		logic [7:0] tag;
	} hdr_t;

	// One result or copy command.
	typedef struct packed {
		logic [3:0] status;
		logic [7:0] tag;
		logic [16:0] doff;
		logic [15:0] clen;
		logic [16:0] alen;
		logic last;
	} res_t;

	// Directed stimulus row; a typed row carries its status and length.
	typedef struct {
		hdr_t h;
		bit typed;
		logic [3:0] st;
		logic [15:0] len;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic [151:0] s_axis_tdata = '0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [63:0] m_axis_tdata;
	logic m_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	ipv4_fragment_reassembly_tracker u_dut (.*);

	always #4 clk = ~clk;

	// Mirror of the block state.
	logic [31:0] my_addr;
	logic [7:0] want_proto;
	bit ctx_valid[MAX_CONTEXTS];
	logic [31:0] ctx_src[MAX_CONTEXTS];
	logic [31:0] ctx_dst[MAX_CONTEXTS];
	logic [23:0] ctx_key[MAX_CONTEXTS];
	int frag_cnt[MAX_CONTEXTS];
	int frag_start[MAX_CONTEXTS][MAX_FRAGMENTS];
	int frag_bytes[MAX_CONTEXTS][MAX_FRAGMENTS];
	bit frag_more[MAX_CONTEXTS][MAX_FRAGMENTS];
	logic [7:0] frag_tag[MAX_CONTEXTS][MAX_FRAGMENTS];

	res_t pending_results[$];
	int errors = 0;
	int idle_mode = 0;
	bit hold_go = 0;
	bit hold_seen = 0;
	int hold_cnt = 0;
	int sent = 0;

	function automatic res_t mk_res(logic [3:0] st, logic [7:0] tag, int doff, int clen,
			int alen, bit lst);
		res_t r;
		r.status = st;
		r.tag = tag;
		r.doff = doff[16:0];
		r.clen = clen[15:0];
		r.alen = alen[16:0];
		r.last = lst;
		return r;
	endfunction

	// Computes the results of one header and updates the context mirror.
	function automatic void reassemble_predict(hdr_t h, bit queue_it);
		res_t outs[$];
		int hlen, c, pos, cnt, run, n, a, b, ln;
		logic [23:0] key;
		bit done;
		hlen = h.hwords * 4;
		key = {h.ident, h.proto};
		done = 1;
		if (h.ver != IPVERSION || h.proto != want_proto)
			outs.push_back(mk_res(ST_VERSION_PROTO, h.tag, 0, 0, 0, 1));
		else if (h.recv < 20)
			outs.push_back(mk_res(ST_SHORT, h.tag, 0, 0, 0, 1));
		else if (hlen < 20 || !h.sum_ok)
			outs.push_back(mk_res(ST_BAD_HEADER, h.tag, 0, 0, 0, 1));
		else if (h.recv < h.total || h.total < hlen)
			outs.push_back(mk_res(ST_BAD_LENGTH, h.tag, 0, 0, 0, 1));
		else if (my_addr != 0 && h.dst != my_addr)
			outs.push_back(mk_res(ST_NOT_OURS, h.tag, 0, 0, 0, 1));
		else if (!h.mf && h.off == 0) begin
			a = h.recv - (hlen - 20);
			b = h.total - hlen;
			ln = (a < b) ? a : b;
			outs.push_back(mk_res(ST_WHOLE, h.tag, 0, ln, ln, 1));
		end else
			done = 0;
		if (!done) begin
			c = -1;
			for (int i = 0; i < MAX_CONTEXTS; i++)
				if (c < 0 && ctx_valid[i] && ctx_src[i] == h.src && ctx_dst[i] == h.dst
						&& ctx_key[i] == key)
					c = i;
			if (c < 0) begin
				for (int i = 0; i < MAX_CONTEXTS; i++)
					if (c < 0 && !ctx_valid[i])
						c = i;
				if (c >= 0) begin
					ctx_valid[c] = 1;
					ctx_src[c] = h.src;
					ctx_dst[c] = h.dst;
					ctx_key[c] = key;
					frag_cnt[c] = 0;
				end
			end
			if (c < 0)
				outs.push_back(mk_res(ST_NO_ROOM, h.tag, 0, 0, 0, 1));
			else begin
				cnt = frag_cnt[c];
				pos = cnt;
				for (int i = 0; i < cnt; i++) begin
					if (!done && frag_start[c][i] == h.off) begin
						outs.push_back(mk_res(ST_DUPLICATE, h.tag, 0, 0, 0, 1));
						done = 1;
					end
					if (!done && pos == cnt && h.off < frag_start[c][i])
						pos = i;
				end
				if (!done && cnt >= MAX_FRAGMENTS) begin
					ctx_valid[c] = 0;
					frag_cnt[c] = 0;
					outs.push_back(mk_res(ST_NO_ROOM, h.tag, 0, 0, 0, 1));
					done = 1;
				end
				if (!done) begin
					for (int i = cnt; i > pos; i--) begin
						frag_start[c][i] = frag_start[c][i-1];
						frag_bytes[c][i] = frag_bytes[c][i-1];
						frag_more[c][i] = frag_more[c][i-1];
						frag_tag[c][i] = frag_tag[c][i-1];
					end
					frag_start[c][pos] = h.off;
					frag_bytes[c][pos] = h.total - hlen;
					frag_more[c][pos] = h.mf;
					frag_tag[c][pos] = h.tag;
					cnt++;
					frag_cnt[c] = cnt;
					// Contiguity walk from offset zero, then the final flag.
					n = 0;
					for (int i = 0; i < cnt; i++) begin
						if (!done && frag_start[c][i] * 8 != n) begin
							outs.push_back(mk_res(ST_HELD, h.tag, 0, 0, 0, 1));
							done = 1;
						end
						n += frag_bytes[c][i];
					end
					if (!done && frag_more[c][cnt-1]) begin
						outs.push_back(mk_res(ST_HELD, h.tag, 0, 0, 0, 1));
						done = 1;
					end
					if (!done) begin
						run = 0;
						for (int i = 0; i < cnt; i++) begin
							outs.push_back(mk_res(ST_REASSEMBLED, frag_tag[c][i], run,
								frag_bytes[c][i], n, i + 1 == cnt));
							run += frag_bytes[c][i];
						end
						for (int i = 0; i < MAX_CONTEXTS; i++) begin
							ctx_valid[i] = 0;
							frag_cnt[i] = 0;
						end
					end
				end
			end
		end
		if (queue_it)
			foreach (outs[i])
				pending_results.push_back(outs[i]);
	endfunction

	// Receiver: random stalls by phase, plus one long hold-off on request.
	always @(posedge clk) begin
		if (hold_go && !hold_seen) begin
			hold_seen <= 1;
			hold_cnt <= 400;
			m_axis_tready <= 0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_axis_tready <= 0;
		end else if (idle_mode == 2)
			m_axis_tready <= ($urandom_range(0, 99) >= 61);
		else if (idle_mode == 3)
			m_axis_tready <= ($urandom_range(0, 99) >= 14);
		else
			m_axis_tready <= 1;
	end

	// Compares each result transaction with the oldest expectation.
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = mk_res(m_axis_tdata[3:0], m_axis_tdata[11:4], m_axis_tdata[28:12],
				m_axis_tdata[44:29], m_axis_tdata[61:45], m_axis_tlast);
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction, status %0d", got.status);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.status != want.status) begin
					$error("status: expected %0d, actual %0d", want.status, got.status);
					errors++;
				end
				if (got.tag != want.tag) begin
					$error("out_tag: expected %0d, actual %0d", want.tag, got.tag);
					errors++;
				end
				if (got.doff != want.doff) begin
					$error("dest_offset: expected %0d, actual %0d", want.doff, got.doff);
					errors++;
				end
				if (got.clen != want.clen) begin
					$error("chunk_length: expected %0d, actual %0d", want.clen, got.clen);
					errors++;
				end
				if (got.alen != want.alen) begin
					$error("assembled_length: expected %0d, actual %0d", want.alen,
						got.alen);
					errors++;
				end
				if (got.last != want.last) begin
					$error("last: expected %0d, actual %0d", want.last, got.last);
					errors++;
				end
			end
		end
	end

	// Offers one header and waits for its transaction.
	task automatic offer_header(hdr_t h, bit queue_it);
		int p;
		p = (idle_mode == 1) ? 61 : (idle_mode == 3) ? 14 : 0;
		if ($urandom_range(0, 99) < p) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
			while ($urandom_range(0, 99) < p)
				@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {1'b0, h.tag, h.mf, h.off, h.ident, h.dst, h.src, h.recv, h.total,
			h.sum_ok, h.hwords, h.proto, h.ver};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		reassemble_predict(h, queue_it);
		sent++;
	endtask

	// Waits until every expected result is in and the block has settled.
	task automatic drain_results();
		s_axis_tvalid <= 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		if (idx == REG_MY_ADDRESS)
			my_addr = val;
		else if (idx == REG_EXPECTED_PROTOCOL)
			want_proto = val[7:0];
	endtask

	function automatic hdr_t good_header(int hw, int bytes);
		hdr_t h;
		h.ver = IPVERSION;
		h.proto = want_proto;
		h.hwords = hw;
		h.sum_ok = 1;
		h.total = hw * 4 + bytes;
		h.recv = h.total + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : 0);
		h.src = $urandom;
		h.dst = (my_addr != 0) ? my_addr : $urandom;
		h.ident = $urandom;
		h.off = 0;
		h.mf = 0;
		h.tag = $urandom;
		return h;
	endfunction

	function automatic hdr_t noise_header();
		hdr_t h;
		h.ver = $urandom;
		h.proto = $urandom;
		h.hwords = $urandom;
		h.sum_ok = $urandom;
		h.total = $urandom;
		h.recv = $urandom;
		h.src = $urandom;
		h.dst = $urandom;
		h.ident = $urandom;
		h.off = $urandom;
		h.mf = $urandom;
		h.tag = $urandom;
		if ($urandom_range(0, 1)) begin
			h.ver = IPVERSION;
			h.proto = want_proto;
			h.sum_ok = 1;
		end
		if ($urandom_range(0, 2) == 0)
			h.dst = my_addr;
		return h;
	endfunction

	// Sends one fragmented datagram in random order, sometimes with a defect.
	task automatic send_datagram();
		hdr_t base, frags[$], tmp;
		int n, hw, units, bytes, j, defect;
		base = good_header(5, 0);
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 18) : $urandom_range(2, 6);
		units = 0;
		for (int i = 0; i < n; i++) begin
			hw = $urandom_range(5, 15);
			bytes = (i == n - 1) ? $urandom_range(0, 200) : 8 * $urandom_range(1, 16);
			tmp = good_header(hw, bytes);
			tmp.src = base.src;
			tmp.dst = base.dst;
			tmp.ident = base.ident;
			tmp.off = units;
			tmp.mf = (i != n - 1);
			frags.push_back(tmp);
			units += bytes / 8;
		end
		for (int i = n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = frags[i];
			frags[i] = frags[j];
			frags[j] = tmp;
		end
		defect = $urandom_range(0, 7);
		if (defect == 0)
			frags.delete($urandom_range(0, n - 1));
		else if (defect == 1)
			frags.insert($urandom_range(0, n - 1), frags[$urandom_range(0, n - 1)]);
		foreach (frags[i])
			offer_header(frags[i], 1);
	endtask

	function automatic row_t mk_row(int ver, int proto, int hw, int ok, int total, int recv,
			int id, int off, int mf, bit typed, logic [3:0] st, int ln);
		row_t r;
		r.h.ver = ver;
		r.h.proto = proto;
		r.h.hwords = hw;
		r.h.sum_ok = ok;
		r.h.total = total;
		r.h.recv = recv;
		r.h.src = 32'h0A000001;
		r.h.dst = 32'hC0A80001;
		r.h.ident = id;
		r.h.off = off;
		r.h.mf = mf;
		r.h.tag = 8'h10 + off[3:0] + id[3:0];
		r.typed = typed;
		r.st = st;
		r.len = ln;
		return r;
	endfunction

	initial begin
		row_t rows[$];
		hdr_t h;
		int pick;
		logic [31:0] addr_set[4];
		logic [7:0] proto_set[4];
		my_addr = 0;
		want_proto = 17;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// Directed rows: rejects, length extremes, reassembly, duplicate, no room.
		rows.push_back(mk_row(5, 17, 5, 1, 40, 40, 0, 0, 0, 1, ST_VERSION_PROTO, 0));
		rows.push_back(mk_row(4, 6, 5, 1, 40, 40, 0, 0, 0, 1, ST_VERSION_PROTO, 0));
		rows.push_back(mk_row(4, 17, 5, 1, 19, 19, 0, 0, 0, 1, ST_SHORT, 0));
		rows.push_back(mk_row(4, 17, 4, 1, 40, 40, 0, 0, 0, 1, ST_BAD_HEADER, 0));
		rows.push_back(mk_row(4, 17, 5, 0, 40, 40, 0, 0, 0, 1, ST_BAD_HEADER, 0));
		rows.push_back(mk_row(4, 17, 5, 1, 60, 59, 0, 0, 0, 1, ST_BAD_LENGTH, 0));
		rows.push_back(mk_row(4, 17, 6, 1, 20, 40, 0, 0, 0, 1, ST_BAD_LENGTH, 0));
		rows.push_back(mk_row(4, 17, 15, 1, 65535, 65535, 0, 0, 0, 1, ST_WHOLE, 65475));
		rows.push_back(mk_row(4, 17, 5, 1, 20, 20, 0, 0, 0, 1, ST_WHOLE, 0));
		rows.push_back(mk_row(4, 17, 5, 1, 36, 36, 1, 0, 1, 0, 0, 0));
		rows.push_back(mk_row(4, 17, 5, 1, 30, 30, 1, 2, 0, 0, 0, 0));
		rows.push_back(mk_row(4, 17, 5, 1, 36, 36, 2, 0, 1, 0, 0, 0));
		rows.push_back(mk_row(4, 17, 5, 1, 36, 36, 2, 0, 1, 0, 0, 0));
		rows.push_back(mk_row(4, 17, 5, 1, 28, 28, 3, 8191, 0, 0, 0, 0));
		rows.push_back(mk_row(4, 17, 5, 1, 28, 28, 10, 1, 1, 0, 0, 0));
		rows.push_back(mk_row(4, 17, 5, 1, 28, 28, 11, 1, 1, 0, 0, 0));
		rows.push_back(mk_row(4, 17, 5, 1, 28, 28, 12, 1, 1, 0, 0, 0));
		foreach (rows[i]) begin
			offer_header(rows[i].h, !rows[i].typed);
			if (rows[i].typed)
				pending_results.push_back(mk_res(rows[i].st, rows[i].h.tag, 0, rows[i].len,
					rows[i].len, 1));
		end
		drain_results();

		// Random phases, each under its own register setting and idling pattern.
		addr_set = '{32'hFFFFFFFF, 32'h0, 32'hC0A80001, 32'h0};
		proto_set = '{8'd255, 8'd0, 8'd17, 8'd6};
		for (int ph = 0; ph < 8; ph++) begin
			drain_results();
			write_reg(REG_MY_ADDRESS, addr_set[ph % 4]);
			write_reg(REG_EXPECTED_PROTOCOL, proto_set[(ph + 1) % 4]);
			idle_mode = ph % 4;
			if (ph == 5)
				hold_go <= 1;
			while (sent < 17 + (ph + 1) * 47) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					send_datagram();
				else if (pick < 85) begin
					h = good_header($urandom_range(5, 15), $urandom_range(0, 1500));
					offer_header(h, 1);
				end else
					offer_header(noise_header(), 1);
			end
		end
		drain_results();
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Generous run limit.
	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/ipvfr_pkg.sv
hw/rtl/ipvfr_front.sv
hw/rtl/ipvfr_queue.sv
hw/rtl/ipvfr_back.sv
hw/rtl/ipv4_fragment_reassembly_tracker.sv
bench/tb_top.sv
